// ===== sv/frq_pkg.sv =====
// frq_pkg: sizes, command and status codes and word types for the frame ring queue.
// No dependencies; used by frq_ram users and frame_ring_queue.
package frq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FRAME_BYTES = 32;

  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OFF_W       = $clog2(FRAME_BYTES);
  localparam int STORE_DEPTH = QUEUE_DEPTH << OFF_W;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OFF_W-1:0] off_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_frame;
  } req_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
    logic [3:0] frame_count;
  } rsp_t;

endpackage

// ===== sv/frq_ram.sv =====
// frq_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module frq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/frame_ring_queue.sv =====
// frame_ring_queue: ring queue of variable-length byte frames, one slot kept free.
// Depends on frq_pkg and frq_ram (frame byte store and frame length store).
//
//   channel  valid      stall      word   carries
//   request  req_valid  req_stall  req    command, data_byte, has_byte, end_of_frame
//   result   rsp_valid  rsp_stall  rsp    byte_out, byte_valid, last, status, frame_count
//
// Push, clear and pop on an empty queue: one word per cycle while the result is not stalled.
// Pop of a frame: accept, length store read, then one byte a cycle from the byte store port
// while the result is not stalled; an empty frame ends after the length read.
// Reset clears state, rsp_valid, pointers and push state; the stores need no clearing pass.
// A stalled result holds the byte stream; requests are stalled while a pop runs.
module frame_ring_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  frq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output frq_pkg::rsp_t rsp
);
  import frq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LEN, S_BYTES} state_t;

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t frames_held(idx_t h, idx_t t);
    logic [IDX_W:0] diff;
    diff = {1'b0, t} - {1'b0, h};
    if (diff[IDX_W]) begin
      diff = diff + DEPTH_X;
    end
    return diff[IDX_W-1:0];
  endfunction

  state_t state;
  idx_t   head, tail, head_next, tail_next;
  off_t   write_offset;
  logic   push_dropping, in_frame;

  idx_t       pop_slot;
  off_t       pop_len, rd_idx, rd_addr;
  logic [3:0] pop_cnt;

  idx_t held;
  logic out_free, accept;
  logic start, drop_eff, wr_byte;
  off_t off_eff, off_new;

  logic       store_we, len_we;
  logic [7:0] store_rdata;
  off_t       len_rdata;
  idx_t       len_raddr;

  assign held      = frames_held(head, tail);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !(state == S_IDLE && out_free);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    start    = !in_frame;
    off_eff  = start ? '0 : write_offset;
    drop_eff = start ? (held == idx_t'(QUEUE_DEPTH - 1)) : push_dropping;
    wr_byte  = req.has_byte && !drop_eff && ({1'b0, off_eff} < (OFF_W + 1)'(FRAME_BYTES - 1));
    off_new  = wr_byte ? off_t'(off_eff + 1'b1) : off_eff;
  end

  assign store_we  = accept && req.command == CMD_PUSH && wr_byte;
  assign len_we    = accept && req.command == CMD_PUSH && req.end_of_frame && !drop_eff;
  assign len_raddr = (state == S_IDLE) ? head : pop_slot;

  // byte address presented now is the one whose data is seen next cycle
  always_comb begin
    rd_addr = '0;
    if (state == S_BYTES) begin
      rd_addr = out_free ? off_t'(rd_idx + 1'b1) : rd_idx;
    end
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (accept) begin
      case (req.command)
        CMD_PUSH: begin
          if (len_we) begin
            tail_next = idx_inc(tail);
          end
        end
        CMD_POP: begin
          if (held != '0) begin
            head_next = idx_inc(head);
          end
        end
        CMD_CLEAR: begin
          head_next = '0;
          tail_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  frq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr ({tail, off_eff}),
    .wdata (req.data_byte),
    .raddr ({pop_slot, rd_addr}),
    .rdata (store_rdata)
  );

  frq_ram #(.WIDTH(OFF_W), .DEPTH(QUEUE_DEPTH)) u_len (
    .clk   (clk),
    .we    (len_we),
    .waddr (tail),
    .wdata (off_new),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      head          <= '0;
      tail          <= '0;
      write_offset  <= '0;
      push_dropping <= 1'b0;
      in_frame      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      head <= head_next;
      tail <= tail_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.command)
              CMD_PUSH: begin
                if (req.end_of_frame) begin
                  in_frame      <= 1'b0;
                  push_dropping <= 1'b0;
                  write_offset  <= '0;
                  rsp_valid     <= 1'b1;
                  rsp           <= '{byte_out: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                     status: drop_eff ? ST_FULL : ST_OK,
                                     frame_count: 4'(frames_held(head_next, tail_next))};
                end else begin
                  in_frame      <= 1'b1;
                  push_dropping <= drop_eff;
                  write_offset  <= off_new;
                end
              end
              CMD_POP: begin
                if (held == '0) begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{byte_out: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                 status: ST_EMPTY, frame_count: 4'(held)};
                end else begin
                  pop_slot <= head;
                  pop_cnt  <= 4'(frames_held(head_next, tail));
                  state    <= S_LEN;
                end
              end
              CMD_CLEAR: begin
                in_frame      <= 1'b0;
                push_dropping <= 1'b0;
                write_offset  <= '0;
                rsp_valid     <= 1'b1;
                rsp           <= '{byte_out: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                   status: ST_OK, frame_count: 4'd0};
              end
              default: begin
              end
            endcase
          end
        end
        S_LEN: begin
          if (len_rdata == '0) begin
            if (out_free) begin
              rsp_valid <= 1'b1;
              rsp       <= '{byte_out: 8'd0, byte_valid: 1'b0, last: 1'b1,
                             status: ST_OK, frame_count: pop_cnt};
              state     <= S_IDLE;
            end
          end else begin
            pop_len <= len_rdata;
            rd_idx  <= '0;
            state   <= S_BYTES;
          end
        end
        S_BYTES: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{byte_out: store_rdata, byte_valid: 1'b1,
                           last: off_t'(rd_idx + 1'b1) == pop_len,
                           status: ST_OK, frame_count: pop_cnt};
            rd_idx    <= off_t'(rd_idx + 1'b1);
            if (off_t'(rd_idx + 1'b1) == pop_len) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> req_stall)
    else $error("request taken during a pop");

  a_pop_reads_len: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == CMD_POP && held != '0 |=> state == S_LEN)
    else $error("pop of a held frame did not read its length");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.byte_valid |-> rsp.status == ST_OK && state != S_LEN)
    else $error("byte word with bad status");

  a_idle_push: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> write_offset == '0 && !push_dropping)
    else $error("push state left over outside a frame");
`endif

endmodule
